>>> hdl/pfb_pkg.sv
`timescale 1ns / 1ps

package pfb_pkg;

    localparam int DisplayWidth  = 128;
    localparam int DisplayHeight = 64;
    localparam int NumPages      = DisplayHeight / 8;
    localparam int StoreDepth    = DisplayWidth * NumPages;
    localparam int AddrWidth     = $clog2(StoreDepth);
    localparam int PageWidth     = $clog2(NumPages);

    localparam logic [1:0] OpFill   = 2'd0;
    localparam logic [1:0] OpBlit   = 2'd1;
    localparam logic [1:0] OpRead   = 2'd2;
    // Spare code: does nothing and answers with an all-zero result.
    localparam logic [1:0] OpUnused = 2'd3;

    localparam logic [2:0] RegBlitX   = 3'd0;
    localparam logic [2:0] RegBlitY   = 3'd1;
    localparam logic [2:0] RegWidth   = 3'd2;
    localparam logic [2:0] RegHeight  = 3'd3;
    localparam logic [2:0] RegMask    = 3'd4;
    localparam logic [2:0] RegClipL   = 3'd5;
    localparam logic [2:0] RegClipR   = 3'd6;

    typedef enum logic [3:0] {
        t_ST_IDLE,
        t_ST_CLEAR,
        t_ST_FILL,
        t_ST_RD,
        t_ST_RD_WAIT,
        t_ST_B0_RD,
        t_ST_B0_WR,
        t_ST_B1_RD,
        t_ST_B1_WR,
        t_ST_OUT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic accept;      // capture the input request
        logic sweep_start; // clear sweep address
        logic sweep_wr;    // write sweep byte and advance
        logic rd_issue;    // read the address for the current phase
        logic wr_issue;    // write the merged byte for the current phase
        logic phase1;      // carry page phase
        logic finish_blit; // advance stream position
        logic out_load;    // load the output register
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic sweep_done;
        logic do_p0;
        logic do_p1;
    } t_status;

endpackage

>>> hdl/pfb_datapath.sv
`timescale 1ns / 1ps

module pfb_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    input  logic [1:0]           i_op,
    input  logic [7:0]           i_data,
    input  logic [6:0]           i_rcol,
    input  logic [5:0]           i_rrow,
    input  pfb_pkg::t_cmd        i_cmd,
    output pfb_pkg::t_status     o_status,
    output logic [1:0]           o_op,
    output logic [9:0]           o_result
);

    localparam int AW = pfb_pkg::AddrWidth;
    localparam int PW = pfb_pkg::PageWidth;

    logic [7:0] mem [pfb_pkg::StoreDepth];
    logic [7:0] r_rdata;

    logic signed [7:0] r_blit_x;
    logic [6:0] r_blit_y;
    logic [7:0] r_width, r_height, r_clip_l, r_clip_r;
    logic       r_mask;
    logic [7:0] r_carry, r_scol;
    logic [4:0] r_spage;

    logic [1:0] r_op;
    logic [7:0] r_data;
    logic [6:0] r_rcol;
    logic [5:0] r_rrow;
    logic [AW:0] r_sweep;
    logic [7:0] r_fill;
    logic [9:0] r_result;

    // Geometry, all from registers and stream state.
    logic [5:0]  tex_rows;
    logic [7:0]  sc, sp_l;
    logic [4:0]  sp;
    logic signed [10:0] x0, x1, col, xe, cl;
    logic [4:0]  r0;
    logic [8:0]  r1_raw;
    logic [5:0]  r1;
    logic        bot_clip, drawable, col_ok, last;
    logic [2:0]  shift;
    logic [5:0]  pg0, pg1, pgc;
    logic [7:0]  bits0, bits1, bits, mask;
    logic [8:0]  trim;
    logic [AW-1:0] addr;
    logic        restart;

    assign tex_rows = 6'((9'(r_height) + 9'd7) >> 3);
    assign restart  = ({3'd0, r_spage} >= 8'(tex_rows)) || (r_scol >= r_width);
    assign sc       = restart ? 8'd0 : r_scol;
    assign sp       = restart ? 5'd0 : r_spage;
    assign sp_l     = {3'd0, sp};
    assign shift    = r_blit_y[2:0];
    assign cl       = 11'(signed'({1'b0, r_clip_l}));
    assign x0       = (cl > 11'(r_blit_x)) ? cl : 11'(r_blit_x);
    assign xe       = 11'(r_blit_x) + 11'(signed'({1'b0, r_width}));
    always_comb begin
        x1 = xe;
        if (x1 > 11'sd128) x1 = 11'sd128;
        if (x1 > 11'(signed'({1'b0, r_clip_r}))) x1 = 11'(signed'({1'b0, r_clip_r}));
    end
    assign r0       = 5'(r_blit_y >> 3);
    assign r1_raw   = 9'((10'(r_blit_y) + 10'(r_height) + 10'd7) >> 3);
    assign bot_clip = r1_raw > 9'(pfb_pkg::NumPages);
    assign r1       = bot_clip ? 6'(pfb_pkg::NumPages) : 6'(r1_raw);
    assign drawable = (x1 > x0) && ({1'b0, r0} < r1);
    assign col      = 11'(r_blit_x) + 11'(signed'({1'b0, sc}));
    assign col_ok   = drawable && (col >= x0) && (col < x1) && (r_width != 0)
                      && (tex_rows != 0);
    assign pg0      = 6'(r0) + 6'(sp);
    assign pg1      = pg0 + 6'd1;
    assign last     = (sc == r_width - 8'd1) && (sp_l == 8'(tex_rows) - 8'd1);

    assign bits0 = 8'(r_data << shift) |
                   ((sp != 0 && shift != 0) ? 8'(r_carry >> (4'd8 - 4'(shift))) : 8'd0);
    assign bits1 = (shift != 0) ? 8'(r_data >> (4'd8 - 4'(shift))) : 8'd0;
    assign pgc   = i_cmd.phase1 ? pg1 : pg0;
    assign bits  = i_cmd.phase1 ? bits1 : bits0;
    assign trim  = 9'({pgc, 3'd0} + 9'd8) - 9'(10'(r_blit_y) + 10'(r_height));
    always_comb begin
        mask = 8'd0;
        if (r_mask) begin
            mask = 8'hff;
            if (pgc == 6'(r0)) mask = 8'(8'hff << shift);
            if (!bot_clip && pgc == r1 - 6'd1) mask = mask & (8'hff >> trim[2:0]);
        end
    end

    always_comb begin
        if (r_op == pfb_pkg::OpRead)
            addr = AW'({r_rcol, r_rrow[5:3]});
        else
            addr = AW'(col[6:0] * 10'(pfb_pkg::NumPages)) + AW'(pgc[PW-1:0]);
    end

    assign o_status.sweep_done = r_sweep[AW];
    assign o_status.do_p0 = col_ok && (pg0 < r1);
    assign o_status.do_p1 = col_ok && (sp_l == 8'(tex_rows) - 8'd1) && (pg1 < r1);
    assign o_op     = r_op;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_wr)
            mem[r_sweep[AW-1:0]] <= r_fill;
        else if (i_cmd.wr_issue)
            mem[addr] <= (r_rdata & ~mask) | bits;
        if (i_cmd.rd_issue)
            r_rdata <= mem[addr];
        if (i_cmd.accept) begin
            r_op   <= i_op;
            r_data <= i_data;
            r_rcol <= i_rcol;
            r_rrow <= i_rrow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blit_x <= '0; r_blit_y <= '0; r_width <= '0; r_height <= '0;
            r_mask <= 1'b0; r_clip_l <= '0; r_clip_r <= 8'd128;
            r_carry <= '0; r_scol <= '0; r_spage <= '0;
            r_sweep <= '0; r_fill <= '0; r_result <= '0;
        end else begin
            if (i_cmd.sweep_start) begin
                r_sweep <= '0;
                r_fill  <= (i_cmd.accept && i_data != 8'd0) ? 8'hff : 8'h00;
            end else if (i_cmd.sweep_wr) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (i_cfg_we && i_cfg_idx <= pfb_pkg::RegClipR) begin
                case (i_cfg_idx)
                    pfb_pkg::RegBlitX:  r_blit_x <= i_cfg_data;
                    pfb_pkg::RegBlitY:  r_blit_y <= i_cfg_data[6:0];
                    pfb_pkg::RegWidth:  r_width  <= i_cfg_data;
                    pfb_pkg::RegHeight: r_height <= i_cfg_data;
                    pfb_pkg::RegMask:   r_mask   <= i_cfg_data[0];
                    pfb_pkg::RegClipL:  r_clip_l <= i_cfg_data;
                    pfb_pkg::RegClipR:  r_clip_r <= i_cfg_data;
                    default: ;
                endcase
                r_carry <= '0; r_scol <= '0; r_spage <= '0;
            end else if (i_cmd.finish_blit && r_width != 0 && tex_rows != 0) begin
                if (sp_l + 8'd1 >= 8'(tex_rows)) begin
                    r_spage <= '0;
                    r_carry <= '0;
                    r_scol  <= (sc + 8'd1 >= r_width) ? 8'd0 : sc + 8'd1;
                end else begin
                    r_spage <= sp + 5'd1;
                    r_carry <= r_data;
                    r_scol  <= sc;
                end
            end
            if (i_cmd.out_load) begin
                r_result <= '0;
                if (r_op == pfb_pkg::OpRead
                    && {1'b0, r_rrow} < 7'(pfb_pkg::DisplayHeight))
                    r_result <= {1'b0, r_rdata[r_rrow[2:0]], r_rdata};
                else if (r_op == pfb_pkg::OpBlit && r_width != 0 && tex_rows != 0
                         && last)
                    r_result <= {drawable, 9'd0};
            end
        end
    end

`ifndef SYNTHESIS
    a_sweep_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sweep_wr && !r_sweep[AW] |=> r_sweep == $past(r_sweep) + 1'b1)
        else $error("sweep address did not advance");
    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.sweep_wr && i_cmd.wr_issue))
        else $error("sweep and blit write together");
    a_p1_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.do_p1 |-> o_status.do_p0 || !(pg0 < r1))
        else $error("carry page without own page check");
`endif

endmodule

>>> hdl/pfb_ctrl.sv
`timescale 1ns / 1ps

module pfb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_in_op,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic [1:0]         i_op,
    input  pfb_pkg::t_status   i_status,
    output pfb_pkg::t_cmd      o_cmd
);

    pfb_pkg::t_state r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic acc;

    // Input is taken only in idle, and only when the output slot is free
    // or being emptied this cycle.
    assign o_in_ready  = (r_state == pfb_pkg::t_ST_IDLE) && (!r_out_valid || i_out_ready);
    assign acc         = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            pfb_pkg::t_ST_CLEAR:
                if (i_status.sweep_done) n_state = pfb_pkg::t_ST_IDLE;
            pfb_pkg::t_ST_IDLE:
                if (acc) begin
                    case (i_in_op)
                        pfb_pkg::OpFill: n_state = pfb_pkg::t_ST_FILL;
                        pfb_pkg::OpRead: n_state = pfb_pkg::t_ST_RD;
                        pfb_pkg::OpBlit: n_state = pfb_pkg::t_ST_B0_RD;
                        default:         n_state = pfb_pkg::t_ST_OUT;
                    endcase
                end
            pfb_pkg::t_ST_FILL:
                if (i_status.sweep_done) n_state = pfb_pkg::t_ST_OUT;
            pfb_pkg::t_ST_RD:      n_state = pfb_pkg::t_ST_RD_WAIT;
            pfb_pkg::t_ST_RD_WAIT: n_state = pfb_pkg::t_ST_OUT;
            pfb_pkg::t_ST_B0_RD:
                n_state = i_status.do_p0 ? pfb_pkg::t_ST_B0_WR
                        : (i_status.do_p1 ? pfb_pkg::t_ST_B1_RD : pfb_pkg::t_ST_OUT);
            pfb_pkg::t_ST_B0_WR:
                n_state = i_status.do_p1 ? pfb_pkg::t_ST_B1_RD : pfb_pkg::t_ST_OUT;
            pfb_pkg::t_ST_B1_RD:   n_state = pfb_pkg::t_ST_B1_WR;
            pfb_pkg::t_ST_B1_WR:   n_state = pfb_pkg::t_ST_OUT;
            pfb_pkg::t_ST_OUT:     n_state = pfb_pkg::t_ST_IDLE;
            default:               n_state = pfb_pkg::t_ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.accept = acc;
        case (r_state)
            pfb_pkg::t_ST_IDLE:  o_cmd.sweep_start = acc && (i_in_op == pfb_pkg::OpFill);
            pfb_pkg::t_ST_CLEAR: o_cmd.sweep_wr = !i_status.sweep_done;
            pfb_pkg::t_ST_FILL:  o_cmd.sweep_wr = !i_status.sweep_done;
            pfb_pkg::t_ST_RD:    o_cmd.rd_issue = 1'b1;
            pfb_pkg::t_ST_B0_RD: o_cmd.rd_issue = i_status.do_p0;
            pfb_pkg::t_ST_B0_WR: o_cmd.wr_issue = 1'b1;
            pfb_pkg::t_ST_B1_RD: begin
                o_cmd.rd_issue = 1'b1;
                o_cmd.phase1   = 1'b1;
            end
            pfb_pkg::t_ST_B1_WR: begin
                o_cmd.wr_issue = 1'b1;
                o_cmd.phase1   = 1'b1;
            end
            pfb_pkg::t_ST_OUT: begin
                o_cmd.out_load    = 1'b1;
                o_cmd.finish_blit = (i_op == pfb_pkg::OpBlit);
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        if (r_state == pfb_pkg::t_ST_OUT) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfb_pkg::t_ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_one_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pfb_pkg::t_ST_OUT |=> r_out_valid)
        else $error("result not raised");
    a_idle_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == pfb_pkg::t_ST_IDLE)
        else $error("ready outside idle");
    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_issue |-> $past(o_cmd.rd_issue))
        else $error("write without preceding read");
`endif

endmodule

>>> hdl/page_framebuffer_blitter_unit.sv
`timescale 1ns / 1ps

// Monochrome framebuffer of 128 x 64 pixels held as 1024 column-major page
// bytes in one single-port memory, with a bit blitter. After reset a clearing
// pass zeroes the memory; no request is taken meanwhile. Each request yields
// exactly one result. A fill sweeps the memory at one byte a cycle. Because
// of the single memory port, each page that a bitmap source byte touches (its
// own page and, on a column's last byte, the carry page) needs a read then a write.
// The result register lets a finished result wait while the block idles.
module page_framebuffer_blitter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,   // operation
    input  logic [23:0] s_axis_tdata,   // data[7:0], read_column[14:8], read_row[20:15]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // page_byte[7:0], pixel_bit[8], drew[9]
);

    pfb_pkg::t_cmd    cmd;
    pfb_pkg::t_status status;
    logic [1:0]       op;
    logic [9:0]       result;

    pfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_op     (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_op        (op),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pfb_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_op       (s_axis_tuser),
        .i_data     (s_axis_tdata[7:0]),
        .i_rcol     (s_axis_tdata[14:8]),
        .i_rrow     (s_axis_tdata[20:15]),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_op       (op),
        .o_result   (result)
    );

    assign m_axis_tdata = {6'd0, result};

endmodule

>>> verif/page_framebuffer_blitter_unit_test.sv
`timescale 1ns / 1ps

module page_framebuffer_blitter_unit_test;

    typedef struct packed {
        logic [7:0] page_byte;
        logic       pixel_bit;
        logic       drew;
    } t_frame_result;

    // Mirror of the framebuffer, its blit registers and the stream position.
    // Every accepted request yields exactly one predicted result.
    class t_frame_scoreboard;
        byte unsigned   store[pfb_pkg::StoreDepth];
        int             bx;
        int unsigned    by, bw, bh, mmode, cl, cr;
        int unsigned    scol, spage;
        byte unsigned   carry;
        t_frame_result  pending[$];
        int             mismatches;

        function void clear_all();
            foreach (store[i]) store[i] = 8'h00;
            bx = 0; by = 0; bw = 0; bh = 0; mmode = 0; cl = 0; cr = 128;
            scol = 0; spage = 0; carry = 0;
            pending.delete();
            mismatches = 0;
        endfunction

        function void note_register(logic [2:0] idx, logic [7:0] v);
            case (idx)
                pfb_pkg::RegBlitX:  bx = $signed(v);
                pfb_pkg::RegBlitY:  by = v & 8'h7f;
                pfb_pkg::RegWidth:  bw = v;
                pfb_pkg::RegHeight: bh = v;
                pfb_pkg::RegMask:   mmode = v[0];
                pfb_pkg::RegClipL:  cl = v;
                pfb_pkg::RegClipR:  cr = v;
                default:            return;
            endcase
            scol = 0; spage = 0; carry = 0;
        endfunction

        function int unsigned cover_mask(int pg, int r0, int r1, bit bclip);
            int unsigned m;
            int unsigned trim;
            if (mmode == 0) return 0;
            m = 8'hff;
            if (pg == r0) m &= (8'hff << (by & 7)) & 8'hff;
            if (!bclip && pg == r1 - 1) begin
                trim = r1 * 8 - (by + bh);
                m &= 8'hff >> (trim & 7);
            end
            return m;
        endfunction

        function void merge_page(int col, int pg, int unsigned clr, int unsigned bits);
            int idx;
            if (col < 0 || col >= pfb_pkg::DisplayWidth || pg < 0 || pg >= pfb_pkg::NumPages)
                return;
            idx = col * pfb_pkg::NumPages + pg;
            store[idx] = ((store[idx] & ~clr) | bits) & 8'hff;
        endfunction

        function void note_request(logic [1:0] op, logic [7:0] data,
                                   logic [6:0] rc, logic [5:0] rr);
            t_frame_result r;
            int unsigned rows, shift, sp, bits;
            int x0, x1, r0, r1, col, pg;
            bit bclip, drawable, last;
            r = '0;
            if (op == pfb_pkg::OpFill) begin
                foreach (store[i]) store[i] = (data != 0) ? 8'hff : 8'h00;
            end else if (op == pfb_pkg::OpRead) begin
                if (rc < pfb_pkg::DisplayWidth && rr < pfb_pkg::NumPages * 8) begin
                    r.page_byte = store[rc * pfb_pkg::NumPages + (rr >> 3)];
                    r.pixel_bit = r.page_byte[rr & 7];
                end
            end else if (op == pfb_pkg::OpBlit) begin
                rows = (bh + 7) / 8;
                if (bw != 0 && rows != 0) begin
                    if (spage >= rows || scol >= bw) begin
                        scol = 0; spage = 0; carry = 0;
                    end
                    x0 = (int'(cl) > bx) ? int'(cl) : bx;
                    if (x0 < 0) x0 = 0;
                    x1 = bx + int'(bw);
                    if (x1 > pfb_pkg::DisplayWidth) x1 = pfb_pkg::DisplayWidth;
                    if (x1 > int'(cr)) x1 = cr;
                    r0 = by / 8;
                    r1 = (by + bh + 7) / 8;
                    bclip = r1 > pfb_pkg::NumPages;
                    if (bclip) r1 = pfb_pkg::NumPages;
                    shift = by & 7;
                    drawable = x1 > x0 && r1 > r0;
                    sp = spage;
                    col = bx + int'(scol);
                    pg = r0 + sp;
                    if (drawable && col >= x0 && col < x1) begin
                        if (pg < r1) begin
                            bits = (data << shift) & 8'hff;
                            if (sp > 0 && shift != 0) bits |= carry >> (8 - shift);
                            merge_page(col, pg, cover_mask(pg, r0, r1, bclip), bits);
                        end
                        if (sp == rows - 1 && pg + 1 < r1) begin
                            bits = shift ? (data >> (8 - shift)) : 0;
                            merge_page(col, pg + 1, cover_mask(pg + 1, r0, r1, bclip), bits);
                        end
                    end
                    last = scol == bw - 1 && sp == rows - 1;
                    carry = data;
                    if (sp + 1 >= rows) begin
                        spage = 0; carry = 0;
                        scol = (scol + 1 >= bw) ? 0 : scol + 1;
                    end else begin
                        spage = sp + 1;
                    end
                    if (last) r.drew = drawable;
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_frame_result got);
            t_frame_result want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h with none outstanding", got);
                return;
            end
            want = pending.pop_front();
            if (got.page_byte !== want.page_byte || got.pixel_bit !== want.pixel_bit ||
                got.drew !== want.drew) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: page_byte %h/%h pixel %b/%b drew %b/%b",
                             want.page_byte, got.page_byte, want.pixel_bit, got.pixel_bit,
                             want.drew, got.drew);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [7:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [1:0]  s_axis_tuser;   // operation
    logic [23:0] s_axis_tdata;   // data[7:0], read_column[14:8], read_row[20:15]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // page_byte[7:0], pixel_bit[8], drew[9]

    page_framebuffer_blitter_unit u_dut (.*);

    t_frame_scoreboard frames;
    int  idle_cycles;
    bit  hold_off;       // asks the receiver for one long stall
    bit  timed_out;
    bit  stimulus_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Requests and results are both taken at the rising edge, where the
    // handshake is settled; nothing is driven there.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                frames.note_request(s_axis_tuser, s_axis_tdata[7:0],
                                    s_axis_tdata[14:8], s_axis_tdata[20:15]);
            if (m_axis_tvalid && m_axis_tready)
                frames.check_result({m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[9]});
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // A fill and the clearing pass after reset each sweep the whole memory, so
    // the watchdog allows well beyond both plus a long stall.
    initial begin
        timed_out = 1'b0;
        wait (idle_cycles > 20000);
        timed_out = 1'b1;
        $display("[page_framebuffer_blitter_unit] ERROR");
        $finish;
    end

    // The receiver stalls on its own pattern, sometimes in runs, sometimes
    // not at all, and once for a long stretch while requests keep coming.
    initial begin
        int n;
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                m_axis_tready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_off = 1'b0;
            end
            n = $urandom_range(0, 9);
            if (n < 2) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end else if (n < 4) begin
                m_axis_tready = 1'b1;
                repeat ($urandom_range(10, 60)) @(negedge i_clk);
            end else begin
                m_axis_tready = $urandom_range(0, 2) != 0;
            end
        end
    end

    // Offers one request and holds it until the block takes it.
    task automatic send_request(logic [1:0] op, logic [7:0] data,
                                logic [6:0] col, logic [5:0] row);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {3'b000, row, col, data};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Waits for every outstanding result; a result is raised only when its
    // request is finished, so the block is then idle.
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (frames.pending.size() != 0 && !timed_out) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [7:0] v);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = v;
        @(posedge i_clk);
        frames.note_register(idx, v);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_blit(logic [7:0] x, logic [7:0] y, logic [7:0] w, logic [7:0] h,
                            logic [7:0] m, logic [7:0] l, logic [7:0] r);
        drain();
        write_register(pfb_pkg::RegBlitX, x);
        write_register(pfb_pkg::RegBlitY, y);
        write_register(pfb_pkg::RegWidth, w);
        write_register(pfb_pkg::RegHeight, h);
        write_register(pfb_pkg::RegMask, m);
        write_register(pfb_pkg::RegClipL, l);
        write_register(pfb_pkg::RegClipR, r);
    endtask

    // Optional random gap between requests, so bursts come with pauses.
    task automatic sender_gap();
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
    endtask

    // Streams the given number of random bitmap source bytes, then reads back a
    // few pixels at random places on the display.
    task automatic blit_bitmap(int unsigned bytes);
        for (int i = 0; i < bytes; i++) begin
            send_request(pfb_pkg::OpBlit, $urandom, $urandom, $urandom);
            sender_gap();
        end
        repeat ($urandom_range(2, 6)) begin
            send_request(pfb_pkg::OpRead, $urandom, $urandom_range(0, 127),
                         $urandom_range(0, 63));
            sender_gap();
        end
    endtask

    initial begin
        int unsigned sent;
        int unsigned w, h, op;
        bit stalled_once;
        frames = new();
        frames.clear_all();
        idle_cycles   = 0;
        hold_off      = 1'b0;
        stalled_once  = 1'b0;
        stimulus_done = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = '0;
        s_axis_tdata  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: reads at opposite corners, a blit with an empty bitmap,
        // a fill of both colours, an unused operation.
        send_request(pfb_pkg::OpRead, 8'h00, 7'd0, 6'd0);
        send_request(pfb_pkg::OpRead, 8'hff, 7'd127, 6'd63);
        send_request(pfb_pkg::OpBlit, 8'hff, 7'd0, 6'd0);
        send_request(pfb_pkg::OpFill, 8'h01, 7'd0, 6'd0);
        send_request(pfb_pkg::OpRead, 8'h00, 7'd127, 6'd63);
        send_request(pfb_pkg::OpUnused, 8'hff, 7'h7f, 6'h3f);
        send_request(pfb_pkg::OpFill, 8'h00, 7'd0, 6'd0);
        // Bitmap hanging off the left edge, shifted, bottom clipped by the
        // display, masked, with narrowed clip window.
        set_blit(8'hfc, 8'd61, 8'd9, 8'd11, 8'd1, 8'd2, 8'd6);
        blit_bitmap(9 * 2);
        // Extremes: far right start, largest sizes fully off screen.
        set_blit(8'h7f, 8'd127, 8'd255, 8'd255, 8'd0, 8'd128, 8'd128);
        blit_bitmap(4);
        // Bitmap entirely clipped away: nothing drawn on its last byte.
        set_blit(8'h80, 8'd0, 8'd3, 8'd8, 8'd1, 8'd0, 8'd0);
        blit_bitmap(3);
        sent = 40;

        // Random part, mostly complete bitmaps of small size.
        while (sent < 650) begin
            if ($urandom_range(0, 3) == 0) begin
                set_blit($urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom_range(0, 128), $urandom_range(0, 128));
                blit_bitmap($urandom_range(1, 8));
                sent += 8;
            end else begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 20);
                set_blit($urandom_range(0, 20) == 0 ? 8'($urandom) : 8'($urandom_range(0, 130) - 6),
                         $urandom_range(0, 70), w, h, $urandom_range(0, 1),
                         $urandom_range(0, 8) == 0 ? $urandom_range(0, 128) : 0,
                         $urandom_range(0, 8) == 0 ? $urandom_range(0, 128) : 128);
                if (sent > 300 && !stalled_once) begin
                    hold_off     = 1'b1;
                    stalled_once = 1'b1;
                end
                blit_bitmap(w * ((h + 7) / 8) + ($urandom_range(0, 5) == 0 ? 1 : 0));
                sent += w * ((h + 7) / 8) + 4;
            end
            op = $urandom_range(0, 30);
            if (op == 0) send_request(pfb_pkg::OpFill,
                                      $urandom_range(0, 1) ? 8'($urandom) : 8'h00,
                                      $urandom, $urandom);
            else if (op == 1) send_request(pfb_pkg::OpUnused, $urandom, $urandom, $urandom);
        end

        drain();
        repeat (50) @(negedge i_clk);
        if (frames.mismatches == 0 && frames.pending.size() == 0)
            $display("[page_framebuffer_blitter_unit] OK");
        else
            $display("[page_framebuffer_blitter_unit] ERROR");
        $finish;
    end
endmodule
